// ----- design/bfvt_pkg.sv -----
`timescale 1ns / 1ps
// bfvt_pkg: shared constants and codes for the box/frustum visibility test.
// No dependencies.
package bfvt_pkg;

  localparam int NUM_PLANES           = 6;
  localparam int NUM_CORNERS          = 8;
  localparam int NUM_AXES             = 3;
  localparam int COEF_W               = 16;
  localparam int CFG_IDX_W            = 3;
  localparam int CFG_DATA_W           = 64;
  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // plane register layout: a, b, c in the low words, d on top
  localparam int PLANE_D_LSB = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_LEFT   = 3'd0,
    CFG_PLANE_RIGHT  = 3'd1,
    CFG_PLANE_TOP    = 3'd2,
    CFG_PLANE_BOTTOM = 3'd3,
    CFG_PLANE_NEAR   = 3'd4,
    CFG_PLANE_FAR    = 3'd5,
    CFG_TEST_MODE    = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    MODE_CORNER = 1'b0,
    MODE_CENTER = 1'b1
  } test_mode_t;

endpackage

// ----- design/box_frustum_visibility_test_top.sv -----
`timescale 1ns / 1ps
// box_frustum_visibility_test_top: six-stage pipelined box vs. frustum test.
// Depends on bfvt_pkg.
//
// Usage:
//   cfg_*  : write port for the six plane registers and the test mode; always
//            ready, one register per beat. Write only while the pipeline is empty.
//   in_*   : one box (min and max corners) per beat.
//   out_*  : one visible flag per box, in input order.
// The pipeline takes one box every cycle while out_ready is high; the six
// register stages (products, corner sums, center magnitude, squaring partial
// products, square assembly, compare) each hold one box. Each stage carries
// its own valid bit and loads whenever it is empty or its successor loads, so
// bubbles close up and a stalled receiver backs the pipeline up one stage at a
// time; in_ready drops only once every stage holds a box. Reset (rst_n low,
// synchronous) empties the pipeline and clears all planes and the test mode to
// zero.
module box_frustum_visibility_test_top #(
  parameter int COORD_BITS       = bfvt_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = bfvt_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfvt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       in_min_x,
  input  logic signed [COORD_BITS-1:0]       in_min_y,
  input  logic signed [COORD_BITS-1:0]       in_min_z,
  input  logic signed [COORD_BITS-1:0]       in_max_x,
  input  logic signed [COORD_BITS-1:0]       in_max_y,
  input  logic signed [COORD_BITS-1:0]       in_max_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_visible
);
  import bfvt_pkg::*;

  localparam int PW  = COEF_W + COORD_BITS;          // coefficient * coordinate
  localparam int DTW = COEF_W + NORMAL_FRAC_BITS;    // d scaled to distance units
  localparam int DW  = ((PW > DTW) ? PW : DTW) + 2;  // corner distance
  localparam int MW  = DW + 1;                       // center distance (doubled)
  localparam int H   = (MW + 1) / 2;                 // low half of magnitude
  localparam int HW  = MW - H;                       // high half of magnitude
  localparam int EW  = COORD_BITS;                   // box extent
  localparam int SW  = 2 * EW + 2;                   // sum of squared extents
  localparam int LW  = SW + 2 * NORMAL_FRAC_BITS;
  localparam int QW  = (2 * MW > LW) ? 2 * MW : LW;  // compare width

  // configuration registers
  logic [CFG_DATA_W-1:0] plane_r [NUM_PLANES];
  test_mode_t            mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_r[p] <= '0;
      end
      mode_r <= MODE_CORNER;
    end else if (cfg_valid) begin
      if (cfg_index <= CFG_PLANE_FAR) begin
        plane_r[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_TEST_MODE) begin
        mode_r <= test_mode_t'(cfg_data[0]);
      end
    end
  end

  logic signed [COEF_W-1:0] coef  [NUM_PLANES][NUM_AXES];
  logic signed [DTW-1:0]    dterm [NUM_PLANES];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        coef[p][ax] = plane_r[p][ax*COEF_W +: COEF_W];
      end
      dterm[p] = DTW'($signed(plane_r[p][PLANE_D_LSB +: COEF_W])) <<< NORMAL_FRAC_BITS;
    end
  end

  // stage handshake
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: per-plane, per-axis products for both extremes; box extents
  logic signed [COORD_BITS-1:0] lo    [NUM_AXES];
  logic signed [COORD_BITS-1:0] hi    [NUM_AXES];
  logic signed [COORD_BITS:0]   diff  [NUM_AXES];
  logic signed [PW-1:0]         prod_nxt [NUM_PLANES][NUM_AXES][2];
  logic signed [PW-1:0]         prod_r   [NUM_PLANES][NUM_AXES][2];
  logic [EW-1:0]                ext_nxt  [NUM_AXES];
  logic [EW-1:0]                ext_r    [NUM_AXES];

  assign lo[0] = in_min_x;
  assign lo[1] = in_min_y;
  assign lo[2] = in_min_z;
  assign hi[0] = in_max_x;
  assign hi[1] = in_max_y;
  assign hi[2] = in_max_z;

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      diff[ax]    = (COORD_BITS+1)'(hi[ax]) - (COORD_BITS+1)'(lo[ax]);
      ext_nxt[ax] = diff[ax][COORD_BITS] ? EW'(-diff[ax]) : EW'(diff[ax]);
      for (int p = 0; p < NUM_PLANES; p++) begin
        prod_nxt[p][ax][0] = PW'(coef[p][ax]) * PW'(lo[ax]);
        prod_nxt[p][ax][1] = PW'(coef[p][ax]) * PW'(hi[ax]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod_r <= prod_nxt;
      ext_r  <= ext_nxt;
    end
  end

  // stage 2: corner distances and their signs; squared extents
  logic signed [DW-1:0]     cdist [NUM_CORNERS][NUM_PLANES];
  logic [NUM_PLANES-1:0]    pos_nxt [NUM_CORNERS];
  logic [NUM_PLANES-1:0]    pos_r   [NUM_CORNERS];
  logic signed [DW-1:0]     dlo_r   [NUM_PLANES];
  logic signed [DW-1:0]     dhi_r   [NUM_PLANES];
  logic [2*EW-1:0]          esq_nxt [NUM_AXES];
  logic [2*EW-1:0]          esq_r   [NUM_AXES];

  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        cdist[c][p] = DW'(prod_r[p][0][c[0]]) + DW'(prod_r[p][1][c[1]])
                    + DW'(prod_r[p][2][c[2]]) + DW'(dterm[p]);
        pos_nxt[c][p] = !cdist[c][p][DW-1] && (cdist[c][p] != '0);
      end
    end
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      esq_nxt[ax] = (2*EW)'(ext_r[ax]) * (2*EW)'(ext_r[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pos_r <= pos_nxt;
      dlo_r <= cdist[0];
      dhi_r <= cdist[NUM_CORNERS-1];
      esq_r <= esq_nxt;
    end
  end

  // stage 3: doubled center distance = sum of opposite corners; corner verdict
  logic signed [MW-1:0]   d2   [NUM_PLANES];
  logic [MW-1:0]          m_nxt [NUM_PLANES];
  logic [MW-1:0]          m_r   [NUM_PLANES];
  logic [NUM_PLANES-1:0]  cpos_nxt, cpos_r3, cpos_r4, cpos_r5;
  logic [SW-1:0]          s_nxt, s_r3, s_r4;
  logic                   visc_nxt, visc_r3, visc_r4, visc_r5;

  always_comb begin
    visc_nxt = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      d2[p]       = MW'(dlo_r[p]) + MW'(dhi_r[p]);
      cpos_nxt[p] = !d2[p][MW-1] && (d2[p] != '0);
      m_nxt[p]    = cpos_nxt[p] ? '0 : MW'(-d2[p]);
    end
    for (int c = 0; c < NUM_CORNERS; c++) begin
      visc_nxt = visc_nxt | (&pos_r[c]);
    end
    s_nxt = SW'(esq_r[0]) + SW'(esq_r[1]) + SW'(esq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m_r     <= m_nxt;
      cpos_r3 <= cpos_nxt;
      s_r3    <= s_nxt;
      visc_r3 <= visc_nxt;
    end
  end

  // stage 4: square of magnitude as three half-width partial products
  logic [2*HW-1:0]   hh_nxt [NUM_PLANES];
  logic [HW+H-1:0]   hl_nxt [NUM_PLANES];
  logic [2*H-1:0]    ll_nxt [NUM_PLANES];
  logic [2*HW-1:0]   hh_r   [NUM_PLANES];
  logic [HW+H-1:0]   hl_r   [NUM_PLANES];
  logic [2*H-1:0]    ll_r   [NUM_PLANES];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      hh_nxt[p] = (2*HW)'(m_r[p][MW-1:H]) * (2*HW)'(m_r[p][MW-1:H]);
      hl_nxt[p] = (HW+H)'(m_r[p][MW-1:H]) * (HW+H)'(m_r[p][H-1:0]);
      ll_nxt[p] = (2*H)'(m_r[p][H-1:0]) * (2*H)'(m_r[p][H-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      hh_r    <= hh_nxt;
      hl_r    <= hl_nxt;
      ll_r    <= ll_nxt;
      cpos_r4 <= cpos_r3;
      s_r4    <= s_r3;
      visc_r4 <= visc_r3;
    end
  end

  // stage 5: assemble squares and the radius limit
  logic [QW-1:0] msq_nxt [NUM_PLANES];
  logic [QW-1:0] msq_r   [NUM_PLANES];
  logic [QW-1:0] lim_nxt, lim_r;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      msq_nxt[p] = (QW'(hh_r[p]) << (2*H)) + (QW'(hl_r[p]) << (H+1)) + QW'(ll_r[p]);
    end
    lim_nxt = QW'(s_r4) << (2*NORMAL_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      msq_r   <= msq_nxt;
      lim_r   <= lim_nxt;
      cpos_r5 <= cpos_r4;
      visc_r5 <= visc_r4;
    end
  end

  // stage 6: center verdict, mode select, output register
  logic center_ok;
  logic vis_nxt, vis_r;

  always_comb begin
    center_ok = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      center_ok = center_ok & (cpos_r5[p] | (msq_r[p] < lim_r));
    end
    vis_nxt = (mode_r == MODE_CENTER) ? center_ok : visc_r5;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      vis_r <= vis_nxt;
    end
  end

  assign out_valid   = v6_r;
  assign out_visible = vis_r;

  // an empty output stage must open the whole chain
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !v6_r |-> in_ready)
    else $error("in_ready low with empty output stage");

  // an accepted beat lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted beat lost at stage 1");

  // a box moves from stage 2 to stage 3 when stage 3 loads
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && en3 |=> v3_r)
    else $error("box dropped between stages 2 and 3");

  // a box held behind a stalled output stage stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !en6 |=> v5_r && v6_r)
    else $error("box dropped during stall");

endmodule
